// File: rtl/mpaq_pkg.sv
// Shared types, constants and a helper function of the motion packet queue.
`timescale 1ns / 1ps

package mpaq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int FIELDS_PER_ENTRY    = 7;
    localparam int WORD_SEL_W          = 3;
    localparam int COORD_W             = 32;
    localparam int KIND_W              = 3;
    localparam int SEQ_W               = 4;
    localparam int TAG_W               = KIND_W + SEQ_W;
    localparam int STATUS_W            = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CLEAR,
        ST_RESULT,
        ST_POP,
        ST_POP_READ
    } fsm_state_t;

    function automatic logic [KIND_W-1:0] kind_of(input logic [3:0] nibble);
        logic [KIND_W-1:0] kind;
        case (nibble)
            4'd1:    kind = 3'd1;
            4'd2:    kind = 3'd2;
            4'd3:    kind = 3'd3;
            4'd8:    kind = 3'd4;
            4'd15:   kind = 3'd5;
            default: kind = 3'd0;
        endcase
        return kind;
    endfunction

endpackage

// File: rtl/mpaq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module mpaq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/motion_packet_assembler_queue_unit.sv
// Top level of the motion packet assembler with its ring queue of commands.
`timescale 1ns / 1ps

// Packets are assembled into commands held in a ring of QUEUE_DEPTH entries; every transaction
// on the input gives exactly one result transaction. The coordinate words live in one RAM with
// eight word slots per entry and the type and sequence tags in a second RAM, both with one read
// port and a registered read. For a packet that adds to the newest command, a dropped packet
// and an empty pop, the tag is read and then the output register is loaded. A packet that
// starts a command first clears the seven words of the new entry through the single write
// port, one per cycle. A pop reads the seven coordinate words in turn through the single read
// port, and its result is loaded when the last read returns. The next transaction is accepted
// in the cycle after the previous one has produced its result, even while that result still
// waits in the output register; a result that finds the output register still occupied waits
// for it, so a stalled receiver delays the result.
module motion_packet_assembler_queue_unit #(
    parameter int QUEUE_DEPTH = mpaq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [7:0]                    type_byte,
    input  logic [7:0]                    seq_param_byte,
    input  logic [31:0]                   coord_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [31:0]                   pos_x,
    output logic [31:0]                   pos_y,
    output logic [31:0]                   pos_z,
    output logic [31:0]                   arc_i,
    output logic [31:0]                   arc_j,
    output logic [31:0]                   arc_k,
    output logic [31:0]                   dwell_p,
    output logic [2:0]                    kind_code,
    output logic [3:0]                    sequence_tag
);

    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int WSEL_W      = mpaq_pkg::WORD_SEL_W;
    localparam int COORD_DEPTH = QUEUE_DEPTH * (2 ** WSEL_W);
    localparam int CADDR_W     = IDX_W + WSEL_W;
    localparam int CW          = mpaq_pkg::COORD_W;
    localparam int TW          = mpaq_pkg::TAG_W;
    localparam int NF          = mpaq_pkg::FIELDS_PER_ENTRY;

    mpaq_pkg::fsm_state_t state_reg, state_next;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WSEL_W-1:0] step_reg, step_next;
    mpaq_pkg::status_t res_status_reg, res_status_next;

    logic [3:0]        type_reg;
    logic [3:0]        seq_reg;
    logic [3:0]        param_reg;
    logic [CW-1:0]     coord_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [CW-1:0]     field_reg [NF];
    logic [2:0]        kind_reg;
    logic [3:0]        seqtag_reg;

    logic              accept;
    logic              out_free;
    logic              param_ok;
    logic              new_cmd;
    logic              full;
    logic              load_result;
    logic              capture_word;
    logic              finish_pop;
    logic [IDX_W-1:0]  newest;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  tail_inc;

    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr;
    logic [TW-1:0]     tag_wdata;
    logic              tag_re;
    logic [IDX_W-1:0]  tag_raddr;
    logic [TW-1:0]     tag_rdata;

    logic              crd_we;
    logic [CADDR_W-1:0] crd_waddr;
    logic [CW-1:0]     crd_wdata;
    logic              crd_re;
    logic [CADDR_W-1:0] crd_raddr;
    logic [CW-1:0]     crd_rdata;

    mpaq_ram #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (tag_re),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    mpaq_ram #(
        .WIDTH (CW),
        .DEPTH (COORD_DEPTH)
    ) u_coord_ram (
        .clk   (clk),
        .we    (crd_we),
        .waddr (crd_waddr),
        .wdata (crd_wdata),
        .re    (crd_re),
        .raddr (crd_raddr),
        .rdata (crd_rdata)
    );

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign param_ok = (param_reg < 4'(NF));
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign new_cmd  = (count_reg == '0) || (tag_rdata[3:0] != seq_reg);
    assign newest   = (tail_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc = (tail_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpaq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = cmd ? mpaq_pkg::ST_POP : mpaq_pkg::ST_EVAL;
                end
            end
            mpaq_pkg::ST_EVAL:
            begin
                if (new_cmd && !full)
                begin
                    state_next = mpaq_pkg::ST_CLEAR;
                end
                else
                begin
                    state_next = mpaq_pkg::ST_RESULT;
                end
            end
            mpaq_pkg::ST_CLEAR:
            begin
                if (step_reg == WSEL_W'(NF - 1))
                begin
                    state_next = mpaq_pkg::ST_RESULT;
                end
            end
            mpaq_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = mpaq_pkg::ST_IDLE;
                end
            end
            mpaq_pkg::ST_POP:
            begin
                if (count_reg == '0)
                begin
                    state_next = mpaq_pkg::ST_RESULT;
                end
                else if (out_free)
                begin
                    state_next = mpaq_pkg::ST_POP_READ;
                end
            end
            mpaq_pkg::ST_POP_READ:
            begin
                if (step_reg == WSEL_W'(NF))
                begin
                    state_next = mpaq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpaq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        tag_re          = 1'b0;
        tag_raddr       = newest;
        tag_we          = 1'b0;
        tag_waddr       = tail_reg;
        tag_wdata       = {mpaq_pkg::kind_of(type_reg), seq_reg};
        crd_re          = 1'b0;
        crd_raddr       = {head_reg, step_reg};
        crd_we          = 1'b0;
        crd_waddr       = {newest, param_reg[WSEL_W-1:0]};
        crd_wdata       = coord_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        load_result     = 1'b0;
        capture_word    = 1'b0;
        finish_pop      = 1'b0;
        case (state_reg)
            mpaq_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                tag_re    = in_valid;
                tag_raddr = cmd ? head_reg : newest;
            end
            mpaq_pkg::ST_EVAL:
            begin
                step_next = '0;
                if (new_cmd && full)
                begin
                    res_status_next = mpaq_pkg::STATUS_FULL;
                end
                else if (new_cmd)
                begin
                    tag_we = 1'b1;
                end
                else
                begin
                    res_status_next = mpaq_pkg::STATUS_OK;
                    crd_we          = param_ok;
                end
            end
            mpaq_pkg::ST_CLEAR:
            begin
                crd_we    = 1'b1;
                crd_waddr = {tail_reg, step_reg};
                crd_wdata = (param_ok && (param_reg[WSEL_W-1:0] == step_reg)) ? coord_reg : '0;
                step_next = step_reg + 1'b1;
                if (step_reg == WSEL_W'(NF - 1))
                begin
                    tail_next       = tail_inc;
                    count_next      = count_reg + 1'b1;
                    res_status_next = mpaq_pkg::STATUS_OK;
                end
            end
            mpaq_pkg::ST_RESULT:
            begin
                load_result = out_free;
            end
            mpaq_pkg::ST_POP:
            begin
                step_next = '0;
                if (count_reg == '0)
                begin
                    res_status_next = mpaq_pkg::STATUS_EMPTY;
                end
            end
            mpaq_pkg::ST_POP_READ:
            begin
                crd_re       = (step_reg != WSEL_W'(NF));
                capture_word = (step_reg != '0);
                step_next    = step_reg + 1'b1;
                if (step_reg == WSEL_W'(NF))
                begin
                    finish_pop = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpaq_pkg::ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            res_status_reg <= mpaq_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            res_status_reg <= res_status_next;
            if (load_result || finish_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= type_byte[3:0];
            seq_reg   <= seq_param_byte[7:4];
            param_reg <= seq_param_byte[3:0];
            coord_reg <= coord_word;
        end
        if (load_result)
        begin
            status_reg <= res_status_reg;
            kind_reg   <= '0;
            seqtag_reg <= '0;
            for (int f = 0; f < NF; f++)
            begin
                field_reg[f] <= '0;
            end
        end
        if (capture_word)
        begin
            field_reg[step_reg - 1'b1] <= crd_rdata;
        end
        if (finish_pop)
        begin
            status_reg <= mpaq_pkg::STATUS_OK;
            kind_reg   <= tag_rdata[TW-1:mpaq_pkg::SEQ_W];
            seqtag_reg <= tag_rdata[mpaq_pkg::SEQ_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign pos_x        = field_reg[0];
    assign pos_y        = field_reg[1];
    assign pos_z        = field_reg[2];
    assign arc_i        = field_reg[3];
    assign arc_j        = field_reg[4];
    assign arc_k        = field_reg[5];
    assign dwell_p      = field_reg[6];
    assign kind_code    = kind_reg;
    assign sequence_tag = seqtag_reg;

endmodule

// File: rtl/mpaq_checker.sv
// Port-level checker for the motion packet queue, bound to the top level.
`timescale 1ns / 1ps

module mpaq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] pos_x,
    input logic [31:0] dwell_p,
    input logic [2:0]  kind_code,
    input logic [3:0]  sequence_tag
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pos_x))
        else $error("Result changed or dropped while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second transaction was taken before the first finished.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == mpaq_pkg::STATUS_OK) || (status == mpaq_pkg::STATUS_EMPTY)
                      || (status == mpaq_pkg::STATUS_FULL))
        else $error("Result carries an undefined status code.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != mpaq_pkg::STATUS_OK)
            |-> (pos_x == '0) && (dwell_p == '0) && (kind_code == '0) && (sequence_tag == '0))
        else $error("Error result carries nonzero command fields.");

endmodule

bind motion_packet_assembler_queue_unit mpaq_checker u_mpaq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .pos_x        (pos_x),
    .dwell_p      (dwell_p),
    .kind_code    (kind_code),
    .sequence_tag (sequence_tag)
);
